[rtl/qrr_pkg.sv]
// ----------------------------------------------------------------------------
// qrr_pkg
// Beat types and constants shared by the quadratic real-root solver.
// ----------------------------------------------------------------------------
package qrr_pkg;

    localparam int COEF_W = 16;
    localparam int ROOT_W = 48;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } qrr_in_t;

    typedef struct packed {
        logic signed [ROOT_W-1:0] root_low;
        logic signed [ROOT_W-1:0] root_high;
        logic [1:0]               root_count;
        logic                     degenerate;
    } qrr_out_t;

    // per-beat side info carried along the pipe
    typedef struct packed {
        logic                     a_neg;
        logic signed [COEF_W-1:0] coef_b;
        logic [COEF_W-1:0]        a_mag;
        logic [1:0]               count;
        logic                     degen;
    } qrr_ctl_t;

endpackage

[rtl/quadratic_real_roots.sv]
// ----------------------------------------------------------------------------
// quadratic_real_roots
// Real roots of a*x^2 + b*x + c = 0 in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per cycle sustained while the
// result side takes them. The pipe is two stages for the products and
// the discriminant, 17 + FRAC_BITS stages of the digit-by-digit square
// root (one result bit each), one stage to form the numerators, and
// 18 + FRAC_BITS stages of the two restoring dividers (one quotient bit
// each), then the output register. A stall on the result side holds the
// whole pipe; bubbles are not squeezed out. Roots carry FRAC_BITS fraction
// bits, smaller root first; zero coefficient a sets degenerate.
module quadratic_real_roots
    import qrr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  qrr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output qrr_out_t m_data
);

    localparam int DW        = 2 * COEF_W + 2;
    localparam int SQ_STEPS  = DW / 2 + FRAC_BITS;
    localparam int RW        = SQ_STEPS;
    localparam int RMW       = RW + 2;
    localparam int NW        = RW + 2;
    localparam int NMW       = RW + 1;
    localparam int DIV_STEPS = NMW;
    localparam int DENW      = COEF_W + 1;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 0: products
    logic [COEF_W-1:0]   a_mag, b_mag, c_mag;
    logic                p0_vld_reg;
    logic [2*COEF_W-1:0] p0_bb_reg, p0_ac_reg;
    logic                p0_acneg_reg;
    qrr_ctl_t            p0_ctl_reg;

    always_comb begin
        a_mag = s_data.coef_a[COEF_W-1] ? COEF_W'(-s_data.coef_a) : COEF_W'(s_data.coef_a);
        b_mag = s_data.coef_b[COEF_W-1] ? COEF_W'(-s_data.coef_b) : COEF_W'(s_data.coef_b);
        c_mag = s_data.coef_c[COEF_W-1] ? COEF_W'(-s_data.coef_c) : COEF_W'(s_data.coef_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
        end else if (adv) begin
            p0_vld_reg <= s_valid;
        end
        if (adv) begin
            p0_bb_reg           <= b_mag * b_mag;
            p0_ac_reg           <= a_mag * c_mag;
            p0_acneg_reg        <= (s_data.coef_c != '0) &&
                                   (s_data.coef_a[COEF_W-1] != s_data.coef_c[COEF_W-1]);
            p0_ctl_reg.a_neg    <= s_data.coef_a[COEF_W-1];
            p0_ctl_reg.coef_b   <= s_data.coef_b;
            p0_ctl_reg.a_mag    <= a_mag;
            p0_ctl_reg.count    <= CNT_NONE;
            p0_ctl_reg.degen    <= (s_data.coef_a == '0);
        end
    end

    // stage 1: discriminant and class
    logic [DW-1:0] bb_ext, ac4, d_next;
    qrr_ctl_t      ctl1_next;

    always_comb begin
        bb_ext    = DW'(p0_bb_reg);
        ac4       = {p0_ac_reg, 2'b00};
        ctl1_next = p0_ctl_reg;
        d_next    = '0;
        if (p0_acneg_reg) begin
            d_next = bb_ext + ac4;
        end else if (bb_ext >= ac4) begin
            d_next = bb_ext - ac4;
        end
        if (p0_ctl_reg.degen || (!p0_acneg_reg && bb_ext < ac4)) begin
            ctl1_next.count = CNT_NONE;
            d_next          = '0;
        end else if (d_next == '0) begin
            ctl1_next.count = CNT_ONE;
        end else begin
            ctl1_next.count = CNT_TWO;
        end
    end

    // square root pipe
    logic           sq_vld_reg  [0:SQ_STEPS];
    qrr_ctl_t       sq_ctl_reg  [0:SQ_STEPS];
    logic [DW-1:0]  sq_dsh_reg  [0:SQ_STEPS];
    logic [RMW-1:0] sq_rem_reg  [0:SQ_STEPS];
    logic [RW-1:0]  sq_root_reg [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= p0_vld_reg;
        end
        if (adv) begin
            sq_ctl_reg[0]  <= ctl1_next;
            sq_dsh_reg[0]  <= d_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
        logic [RMW+1:0] remx, trial;
        logic [RMW-1:0] rem_next;
        logic [RW-1:0]  root_next;

        always_comb begin
            remx  = {sq_rem_reg[i], sq_dsh_reg[i][DW-1 -: 2]};
            trial = (RMW+2)'({sq_root_reg[i], 2'b01});
            if (remx >= trial) begin
                rem_next  = RMW'(remx - trial);
                root_next = {sq_root_reg[i][RW-2:0], 1'b1};
            end else begin
                rem_next  = RMW'(remx);
                root_next = {sq_root_reg[i][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
            if (adv) begin
                sq_ctl_reg[i+1]  <= sq_ctl_reg[i];
                sq_dsh_reg[i+1]  <= sq_dsh_reg[i] << 2;
                sq_rem_reg[i+1]  <= rem_next;
                sq_root_reg[i+1] <= root_next;
            end
        end
    end

    // numerators: lane 0 is -b - s, lane 1 is -b + s
    logic signed [NW-1:0] b_ext, nb, s_ext, num_m, num_p;
    logic [NMW-1:0]       mag_m, mag_p;

    always_comb begin
        b_ext = NW'(sq_ctl_reg[SQ_STEPS].coef_b);
        nb    = -(b_ext <<< FRAC_BITS);
        s_ext = signed'({2'b00, sq_root_reg[SQ_STEPS]});
        num_m = nb - s_ext;
        num_p = nb + s_ext;
        mag_m = num_m[NW-1] ? NMW'(-num_m) : NMW'(num_m);
        mag_p = num_p[NW-1] ? NMW'(-num_p) : NMW'(num_p);
    end

    logic            dv_vld_reg [0:DIV_STEPS];
    qrr_ctl_t        dv_ctl_reg [0:DIV_STEPS];
    logic [DENW-1:0] dv_den_reg [0:DIV_STEPS];
    logic            dv_sgn_reg [0:DIV_STEPS][0:1];
    logic [NMW-1:0]  dv_n_reg   [0:DIV_STEPS][0:1];
    logic [NMW-1:0]  dv_q_reg   [0:DIV_STEPS][0:1];
    logic [DENW-1:0] dv_rem_reg [0:DIV_STEPS][0:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
        if (adv) begin
            dv_ctl_reg[0]    <= sq_ctl_reg[SQ_STEPS];
            dv_den_reg[0]    <= {sq_ctl_reg[SQ_STEPS].a_mag, 1'b0};
            dv_sgn_reg[0][0] <= num_m[NW-1] ^ sq_ctl_reg[SQ_STEPS].a_neg;
            dv_sgn_reg[0][1] <= num_p[NW-1] ^ sq_ctl_reg[SQ_STEPS].a_neg;
            dv_n_reg[0][0]   <= mag_m;
            dv_n_reg[0][1]   <= mag_p;
            dv_q_reg[0][0]   <= '0;
            dv_q_reg[0][1]   <= '0;
            dv_rem_reg[0][0] <= '0;
            dv_rem_reg[0][1] <= '0;
        end
    end

    // restoring dividers, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
            if (adv) begin
                dv_ctl_reg[i+1] <= dv_ctl_reg[i];
                dv_den_reg[i+1] <= dv_den_reg[i];
            end
        end

        for (genvar k = 0; k < 2; k++) begin : g_lane
            logic [DENW:0] remx;
            logic          take;

            always_comb begin
                remx = {dv_rem_reg[i][k], dv_n_reg[i][k][NMW-1]};
                take = remx >= (DENW+1)'(dv_den_reg[i]);
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_sgn_reg[i+1][k] <= dv_sgn_reg[i][k];
                    dv_n_reg[i+1][k]   <= dv_n_reg[i][k] << 1;
                    dv_q_reg[i+1][k]   <= {dv_q_reg[i][k][NMW-2:0], take};
                    dv_rem_reg[i+1][k] <= take ? DENW'(remx - (DENW+1)'(dv_den_reg[i]))
                                               : DENW'(remx);
                end
            end
        end
    end

    // sign, order, output register
    logic signed [NMW:0]      qs [0:1];
    logic signed [ROOT_W-1:0] rt [0:1];
    qrr_ctl_t                 ctl_last;
    qrr_out_t                 out_next;

    always_comb begin
        ctl_last = dv_ctl_reg[DIV_STEPS];
        for (int k = 0; k < 2; k++) begin
            qs[k] = dv_sgn_reg[DIV_STEPS][k] ? -signed'({1'b0, dv_q_reg[DIV_STEPS][k]})
                                             :  signed'({1'b0, dv_q_reg[DIV_STEPS][k]});
            rt[k] = ROOT_W'(qs[k]);
        end
        out_next.root_count = ctl_last.count;
        out_next.degenerate = ctl_last.degen;
        if (ctl_last.count == CNT_NONE) begin
            out_next.root_low  = '0;
            out_next.root_high = '0;
        end else if (ctl_last.a_neg) begin
            out_next.root_low  = rt[1];
            out_next.root_high = rt[0];
        end else begin
            out_next.root_low  = rt[0];
            out_next.root_high = rt[1];
        end
    end

    logic     m_valid_reg;
    qrr_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_vld_reg[DIV_STEPS];
        end
        if (adv) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.root_count == CNT_NONE && m_data.root_low == '0)
        else $error("degenerate beat with roots");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.root_count == CNT_NONE |->
            m_data.root_low == '0 && m_data.root_high == '0)
        else $error("no-root beat with nonzero roots");

    a_double_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.root_count == CNT_ONE |-> m_data.root_low == m_data.root_high)
        else $error("double root differs");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.root_count == CNT_TWO |-> m_data.root_low <= m_data.root_high)
        else $error("roots out of order");

endmodule

[sim/quadratic_real_roots_tb.sv]
// ----------------------------------------------------------------------------
// quadratic_real_roots_tb
// Drives coefficient beats into the root solver under several idle/stall
// mixes and checks every result beat against an in-bench fixed-point solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_real_roots_tb;
    import qrr_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 39 + 2 * FRAC;
    localparam logic signed [63:0] RMAX = (64'sd1 <<< 47) - 1;
    localparam logic signed [63:0] RMIN = -(64'sd1 <<< 47);

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    qrr_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    qrr_out_t m_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          errors = 0;
    qrr_out_t    roots_pending[$];

    quadratic_real_roots #(.FRAC_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] isqrt_fixed(logic [63:0] d);
        logic [63:0] rem, root, trial;
        logic [1:0]  pair;
        rem = 0;
        root = 0;
        for (int i = 0; i < 32 + FRAC; i++) begin
            pair = (i < 32) ? d[63-2*i -: 2] : 2'b00;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [ROOT_W-1:0] div_sat(logic signed [63:0] num,
                                                        logic signed [63:0] den);
        logic signed [63:0] q;
        q = num / den;
        if (q > RMAX) q = RMAX;
        if (q < RMIN) q = RMIN;
        return q[ROOT_W-1:0];
    endfunction

    function automatic qrr_out_t solve_roots(qrr_in_t x);
        qrr_out_t r;
        logic signed [63:0] a, b, c, d, nb, den, s;
        logic signed [ROOT_W-1:0] rm, rp;
        r = '0;
        a = x.coef_a;
        b = x.coef_b;
        c = x.coef_c;
        if (a == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        d = b * b - 4 * a * c;
        if (d < 0) return r;
        nb = -b * (64'sd1 <<< FRAC);
        den = 2 * a;
        if (d == 0) begin
            r.root_low = div_sat(nb, den);
            r.root_high = r.root_low;
            r.root_count = CNT_ONE;
            return r;
        end
        s = isqrt_fixed(d);
        rm = div_sat(nb - s, den);
        rp = div_sat(nb + s, den);
        r.root_low = (a > 0) ? rm : rp;
        r.root_high = (a > 0) ? rp : rm;
        r.root_count = CNT_TWO;
        return r;
    endfunction

    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        qrr_in_t x;
        x.coef_a = a;
        x.coef_b = b;
        x.coef_c = c;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        roots_pending.push_back(solve_roots(x));
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        qrr_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (roots_pending.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, m_data);
                errors++;
            end else begin
                e = roots_pending.pop_front();
                if (m_data.root_low !== e.root_low)
                    $display("%0t: root_low exp %h got %h", $time, e.root_low,
                             m_data.root_low);
                if (m_data.root_high !== e.root_high)
                    $display("%0t: root_high exp %h got %h", $time, e.root_high,
                             m_data.root_high);
                if (m_data.root_count !== e.root_count)
                    $display("%0t: root_count exp %0d got %0d", $time,
                             e.root_count, m_data.root_count);
                if (m_data.degenerate !== e.degenerate)
                    $display("%0t: degenerate exp %b got %b", $time,
                             e.degenerate, m_data.degenerate);
                if (m_data !== e) errors++;
            end
        end
    end

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (roots_pending.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed();
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h8000, 16'h8000);
        send_coefs(16'h8000, 16'h7fff, 16'h7fff);
        send_coefs(16'h0001, 16'h8000, 16'h0000);
        send_coefs(16'h0000, 16'h0005, 16'h0003);
        send_coefs(16'h0000, 16'h0000, 16'h0000);
        send_coefs(16'h0001, 16'h0000, 16'h0001);
        send_coefs(16'h0001, 16'hfffe, 16'h0001);
        send_coefs(16'hffff, 16'h0002, 16'hffff);
        send_coefs(16'h0003, 16'h0006, 16'h0003);
        send_coefs(16'h0001, 16'hfffd, 16'h0002);
        send_coefs(16'hffff, 16'h0003, 16'hfffe);
        send_coefs(16'h0001, 16'h0000, 16'h0000);
        send_coefs(16'h0002, 16'h0003, 16'h0000);
        send_coefs(16'h7fff, 16'h0001, 16'h0000);
        send_coefs(16'h7fff, 16'h0000, 16'h8000);
        send_coefs(16'h0001, 16'h7fff, 16'h8000);
        send_coefs(16'hffff, 16'h0000, 16'h7fff);
        send_coefs(16'h8000, 16'h0001, 16'h0000);
        send_coefs(16'h0001, 16'h0000, 16'hffff);
    endtask

    // random beats and equations with chosen integer roots (double and split)
    task automatic send_random(int n);
        logic [15:0] a, b, c;
        int k, p, q;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: begin
                    send_coefs(16'($urandom), 16'($urandom), 16'($urandom));
                end
                1: begin
                    k = $urandom_range(1, 20) * ($urandom_range(1) ? 1 : -1);
                    p = $signed($urandom_range(80)) - 40;
                    send_coefs(16'(k), 16'(-2 * k * p), 16'(k * p * p));
                end
                2: begin
                    k = $urandom_range(1, 20) * ($urandom_range(1) ? 1 : -1);
                    p = $signed($urandom_range(80)) - 40;
                    q = $signed($urandom_range(80)) - 40;
                    send_coefs(16'(k), 16'(-k * (p + q)), 16'(k * p * q));
                end
                default: begin
                    a = 16'($urandom_range(7) - 3);
                    b = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(9) - 4);
                    c = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(9) - 4);
                    send_coefs(a, b, c);
                end
            endcase
        end
    endtask

    task automatic test_phase(int unsigned idle, int unsigned stall, int n);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        send_random(n);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_phase(0, 0, 350);
        wait_drained();
        test_phase(63, 0, 350);
        test_phase(0, 63, 350);
        test_phase(17, 17, 350);
        wait_drained();
        repeat (LATENCY + 10) @(negedge aclk);
        if (errors == 0 && roots_pending.size() == 0) begin
            $display("quadratic_real_roots_tb: done, clean");
        end else begin
            $display("quadratic_real_roots_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("quadratic_real_roots_tb: done, errors");
        $finish;
    end

endmodule
